>>> sv/wsfsg_pkg.sv
// Package for the WS2812 frame slot generator.
// Holds sizes, opcode and state codes, and the controller/datapath structs.
// No dependencies.
package wsfsg_pkg;

   localparam int LED_COUNT         = 256;
   localparam int LED_AW            = $clog2(LED_COUNT);
   localparam int LEAD_RESET_SLOTS  = 50;
   localparam int TRAIL_RESET_SLOTS = 50;
   localparam int BITS_PER_LED      = 24;
   localparam int COLOR_W           = 24;
   localparam int BIT_W             = 5;
   localparam int SLOT_CNT_W        = 8;
   localparam int DUTY_W            = 8;
   localparam int CSR_IDX_W         = 1;
   localparam int ZERO_DUTY_RESET   = 15;
   localparam int ONE_DUTY_RESET    = 30;

   typedef enum logic [2:0] {
      OP_SET_LED    = 3'd0,
      OP_SET_ALL    = 3'd1,
      OP_FILL_BLACK = 3'd2,
      OP_FILL_WHITE = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_START      = 3'd5,
      OP_TICK       = 3'd6
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_DUTY = 1'b0,
      CSR_ONE_DUTY  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_DATA,
      PH_END,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic set_led;
      logic sweep_begin;
      logic sweep_step;
      logic start_frame;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic frame_active;
      logic sweep_done;
      logic rsp_free;
   } dp_sts_type;

endpackage

>>> sv/wsfsg_ctl.sv
// Controller for the WS2812 frame slot generator.
// Decodes accepted requests into datapath commands; uses wsfsg_pkg.
module wsfsg_ctl
   import wsfsg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_opcode,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (opcode_type'(req_opcode)) inside
                  OP_SET_LED: cmd.set_led = 1'b1;
                  OP_SET_ALL, OP_FILL_BLACK, OP_FILL_WHITE, OP_CLEAR: begin
                     cmd.sweep_begin = 1'b1;
                     state_in        = ST_SWEEP;
                  end
                  OP_START: cmd.start_frame = 1'b1;
                  OP_TICK: begin
                     if (sts.frame_active) begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> sv/wsfsg_dp.sv
// Datapath for the WS2812 frame slot generator: colour store, frame counters,
// duty registers and result register. Uses wsfsg_pkg.
module wsfsg_dp
   import wsfsg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [2:0]           req_opcode,
   input  logic [15:0]          req_led_index,
   input  logic [7:0]           req_red_level,
   input  logic [7:0]           req_green_level,
   input  logic [7:0]           req_blue_level,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]    csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DUTY_W-1:0]    rsp_slot_duty,
   output logic                 rsp_frame_end
);

   logic [COLOR_W:0]     mem_ff [LED_COUNT];
   logic [LED_COUNT-1:0] vld_ff;
   logic [COLOR_W:0]     rd_entry_ff;
   logic                 rd_vld_ff;
   logic [LED_AW-1:0]    rd_addr;
   logic                 mem_we;
   logic [LED_AW-1:0]    mem_waddr;
   logic [COLOR_W:0]     mem_wdata;
   logic [COLOR_W-1:0]   req_color;
   logic [COLOR_W-1:0]   rd_color;
   logic [15:0]          led_mod;

   logic [LED_AW:0]      swp_cnt_ff, swp_cnt_in;
   logic                 swp_clear_ff, swp_clear_in;
   logic [COLOR_W-1:0]   swp_color_ff, swp_color_in;
   logic                 end_blank_ff, end_blank_in;

   logic                 active_ff, active_in;
   phase_type            phase_ff, phase_in;
   logic [SLOT_CNT_W-1:0] slot_cnt_ff, slot_cnt_in;
   logic [LED_AW-1:0]    led_ff, led_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [DUTY_W-1:0]    zero_duty_ff, one_duty_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]    rsp_duty_ff, rsp_duty_in;
   logic                 rsp_end_ff, rsp_end_in;
   logic [DUTY_W-1:0]    duty;
   logic                 last_slot;

   assign req_color = {req_green_level, req_red_level, req_blue_level};
   assign led_mod   = 16'(req_led_index % LED_COUNT);
   assign rd_color  = rd_vld_ff ? rd_entry_ff[COLOR_W-1:0] : '0;
   assign rd_addr   = cmd.sweep_step ? swp_cnt_ff[LED_AW-1:0] : led_ff;

   // store write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = led_mod[LED_AW-1:0];
      mem_wdata = {1'b0, req_color};
      if (cmd.set_led) begin
         mem_we = 1'b1;
      end else if (cmd.sweep_step) begin
         if (swp_clear_ff) begin
            mem_we    = (swp_cnt_ff != '0);
            mem_waddr = LED_AW'(swp_cnt_ff - 1'b1);
            mem_wdata = {1'b1, rd_color};
         end else begin
            mem_we    = (swp_cnt_ff != (LED_AW+1)'(LED_COUNT));
            mem_waddr = swp_cnt_ff[LED_AW-1:0];
            mem_wdata = {1'b0, swp_color_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_we) begin
            vld_ff[mem_waddr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // sweep control
   always_comb begin
      swp_cnt_in   = swp_cnt_ff;
      swp_clear_in = swp_clear_ff;
      swp_color_in = swp_color_ff;
      end_blank_in = end_blank_ff;
      if (cmd.sweep_begin) begin
         swp_cnt_in   = '0;
         swp_clear_in = (opcode_type'(req_opcode) == OP_CLEAR);
         case (opcode_type'(req_opcode))
            OP_SET_ALL:    swp_color_in = req_color;
            OP_FILL_WHITE: begin
               swp_color_in = '1;
               end_blank_in = 1'b0;
            end
            OP_FILL_BLACK: begin
               swp_color_in = '0;
               end_blank_in = 1'b0;
            end
            OP_CLEAR:      end_blank_in = 1'b1;
            default:       ;
         endcase
      end else if (cmd.sweep_step) begin
         swp_cnt_in = swp_cnt_ff + 1'b1;
      end
   end

   // slot duty and frame position
   always_comb begin
      duty = '0;
      unique case (phase_ff)
         PH_DATA: begin
            if (!(rd_vld_ff && rd_entry_ff[COLOR_W])) begin
               duty = rd_color[BIT_W'(BITS_PER_LED - 1) - bit_ff] ? one_duty_ff : zero_duty_ff;
            end
         end
         PH_END:  duty = end_blank_ff ? '0 : zero_duty_ff;
         default: duty = '0;
      endcase
   end

   assign last_slot = (phase_ff == PH_TRAIL) &&
                      (slot_cnt_ff == SLOT_CNT_W'(TRAIL_RESET_SLOTS - 1));

   always_comb begin
      active_in   = active_ff;
      phase_in    = phase_ff;
      slot_cnt_in = slot_cnt_ff;
      led_in      = led_ff;
      bit_in      = bit_ff;
      if (cmd.start_frame) begin
         active_in   = 1'b1;
         phase_in    = PH_LEAD;
         slot_cnt_in = '0;
         led_in      = '0;
         bit_in      = '0;
      end else if (cmd.emit) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (slot_cnt_ff == SLOT_CNT_W'(LEAD_RESET_SLOTS - 1)) begin
                  phase_in    = PH_DATA;
                  slot_cnt_in = '0;
               end else begin
                  slot_cnt_in = slot_cnt_ff + 1'b1;
               end
            end
            PH_DATA: begin
               if (bit_ff == BIT_W'(BITS_PER_LED - 1)) begin
                  bit_in = '0;
                  if (led_ff == LED_AW'(LED_COUNT - 1)) begin
                     led_in   = '0;
                     phase_in = PH_END;
                  end else begin
                     led_in = led_ff + 1'b1;
                  end
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
            PH_END: begin
               phase_in    = PH_TRAIL;
               slot_cnt_in = '0;
            end
            PH_TRAIL: begin
               if (last_slot) begin
                  active_in   = 1'b0;
                  phase_in    = PH_LEAD;
                  slot_cnt_in = '0;
               end else begin
                  slot_cnt_in = slot_cnt_ff + 1'b1;
               end
            end
            default: phase_in = PH_LEAD;
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_end_in   = rsp_end_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_duty_in  = duty;
         rsp_end_in   = last_slot;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swp_cnt_ff   <= '0;
         swp_clear_ff <= 1'b0;
         end_blank_ff <= 1'b0;
         active_ff    <= 1'b0;
         phase_ff     <= PH_LEAD;
         slot_cnt_ff  <= '0;
         led_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         zero_duty_ff <= DUTY_W'(ZERO_DUTY_RESET);
         one_duty_ff  <= DUTY_W'(ONE_DUTY_RESET);
      end else begin
         swp_cnt_ff   <= swp_cnt_in;
         swp_clear_ff <= swp_clear_in;
         end_blank_ff <= end_blank_in;
         active_ff    <= active_in;
         phase_ff     <= phase_in;
         slot_cnt_ff  <= slot_cnt_in;
         led_ff       <= led_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index_type'(csr_index))
               CSR_ZERO_DUTY: zero_duty_ff <= csr_wdata;
               CSR_ONE_DUTY:  one_duty_ff  <= csr_wdata;
               default:       ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      swp_color_ff <= swp_color_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign sts.frame_active = active_ff;
   assign sts.sweep_done   = (swp_cnt_ff == (LED_AW+1)'(LED_COUNT));
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot_duty = rsp_duty_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

>>> sv/ws2812_frame_slot_generator_top.sv
// Top level of the WS2812 frame slot generator.
// Joins wsfsg_ctl and wsfsg_dp; uses wsfsg_pkg.
//
// Requests enter on req_valid/req_ready with an opcode, an LED index and a
// colour. Slot duty values leave on rsp_valid/rsp_ready, one per slot tick
// accepted while a frame is active; rsp_frame_end marks the last trailing
// reset slot. Duty codes are written on csr_wen/csr_index/csr_wdata; the user
// must do so only while the block is idle, as the block does not enforce it.
//
// Set LED, start frame, an idle tick and an unused opcode are handled in
// the idle state. An active tick moves the controller to its emit state
// while the colour store read is registered; the emit state then puts the
// duty into the result register once it is free. Set all, fill black, fill
// white and clear walk the colour store one entry a cycle, holding req_ready
// low until every entry is done (clear reads and rewrites each entry).
// Reset clears the store's valid bits, so every LED reads black and
// unblanked, the end slot uses the zero code and no frame is active.
// When rsp_ready is low the result is held, and a following active tick
// waits until the result register frees.
module ws2812_frame_slot_generator_top
   import wsfsg_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_opcode,
   input  logic [15:0]          req_led_index,
   input  logic [7:0]           req_red_level,
   input  logic [7:0]           req_green_level,
   input  logic [7:0]           req_blue_level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DUTY_W-1:0]    rsp_slot_duty,
   output logic                 rsp_frame_end,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]    csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   wsfsg_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   wsfsg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_opcode      (req_opcode),
      .req_led_index   (req_led_index),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot_duty   (rsp_slot_duty),
      .rsp_frame_end   (rsp_frame_end)
   );

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("result register overwritten");

   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> !req_ready)
      else $error("request taken during store sweep");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == OP_TICK && !sts.frame_active)
      |=> (req_ready && !cmd.emit))
      else $error("idle tick stalled or emitted");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode == OP_START) |=> sts.frame_active)
      else $error("frame not active after start");

endmodule

>>> tb/ws2812_frame_slot_generator_top_tb.sv
// Self-checking testbench for ws2812_frame_slot_generator_top: predicts every slot duty
// from its own copy of the colour store and checks the result stream in order.
// Depends on wsfsg_pkg and the RTL of the block only.
module ws2812_frame_slot_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wsfsg_pkg::*;

   localparam int DATA_SLOTS       = LED_COUNT * BITS_PER_LED;
   localparam int END_SLOT_POS     = LEAD_RESET_SLOTS + DATA_SLOTS;
   localparam int FRAME_SLOTS      = END_SLOT_POS + 1 + TRAIL_RESET_SLOTS;
   localparam int CYCLE_LIMIT      = 3_000_000;
   localparam int SWEEP_CYCLES     = LED_COUNT + 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CHUNK_ITEMS      = 320;
   localparam int REPORT_LIMIT     = 20;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct {
      logic [2:0]  opcode;
      logic [15:0] led_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } led_request_type;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic              frame_end;
   } slot_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_opcode = '0;
   logic [15:0]          req_led_index = '0;
   logic [7:0]           req_red_level = '0;
   logic [7:0]           req_green_level = '0;
   logic [7:0]           req_blue_level = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DUTY_W-1:0]    rsp_slot_duty;
   logic                 rsp_frame_end;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ZERO_DUTY;
   logic [DUTY_W-1:0]    csr_wdata = '0;

   // predicted block state
   logic [COLOR_W-1:0] led_colors [LED_COUNT];
   bit                 led_blanked [LED_COUNT];
   bit                 end_blank;
   bit                 frame_running;
   int unsigned        frame_pos;
   logic [DUTY_W-1:0]  zero_duty = DUTY_W'(ZERO_DUTY_RESET);
   logic [DUTY_W-1:0]  one_duty = DUTY_W'(ONE_DUTY_RESET);

   led_request_type request_backlog [$];
   slot_result_type expected_slots [$];
   led_request_type current_request;

   int unsigned errors = 0;
   int unsigned results_seen = 0;
   int unsigned sent_count = 0;
   int unsigned random_items = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned cycle_count = 0;
   bit          send_gaps_on = 1'b1;
   bit          recv_stalls_on = 1'b1;

   ws2812_frame_slot_generator_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_led_index   (req_led_index),
      .req_red_level   (req_red_level),
      .req_green_level (req_green_level),
      .req_blue_level  (req_blue_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot_duty   (rsp_slot_duty),
      .rsp_frame_end   (rsp_frame_end),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic void paint_store(logic [COLOR_W-1:0] color);
      foreach (led_colors[i]) begin
         led_colors[i] = color;
         led_blanked[i] = 1'b0;
      end
   endfunction

   function automatic logic [DUTY_W-1:0] slot_duty_at(int unsigned pos);
      int unsigned offset, led, bit_pos;
      if (pos < LEAD_RESET_SLOTS) return '0;
      if (pos < END_SLOT_POS) begin
         offset = pos - LEAD_RESET_SLOTS;
         led = offset / BITS_PER_LED;
         bit_pos = offset % BITS_PER_LED;
         if (led_blanked[led]) return '0;
         return led_colors[led][COLOR_W-1-bit_pos] ? one_duty : zero_duty;
      end
      if (pos == END_SLOT_POS) return end_blank ? '0 : zero_duty;
      return '0;
   endfunction

   function automatic void predict_request(led_request_type r);
      slot_result_type res;
      int unsigned led;
      case (r.opcode)
         OP_SET_LED: begin
            led = r.led_index % LED_COUNT;
            led_colors[led] = {r.green, r.red, r.blue};
            led_blanked[led] = 1'b0;
         end
         OP_SET_ALL: paint_store({r.green, r.red, r.blue});
         OP_FILL_BLACK: begin
            paint_store('0);
            end_blank = 1'b0;
         end
         OP_FILL_WHITE: begin
            paint_store('1);
            end_blank = 1'b0;
         end
         OP_CLEAR: begin
            foreach (led_blanked[i]) led_blanked[i] = 1'b1;
            end_blank = 1'b1;
         end
         OP_START: begin
            frame_running = 1'b1;
            frame_pos = 0;
         end
         OP_TICK: if (frame_running) begin
            res.duty = slot_duty_at(frame_pos);
            res.frame_end = (frame_pos + 1 >= FRAME_SLOTS);
            if (res.frame_end) begin
               frame_running = 1'b0;
               frame_pos = 0;
            end else begin
               frame_pos++;
            end
            expected_slots.push_back(res);
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned pick_send_gap();
      int unsigned roll;
      if (!send_gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
   endtask

   // request driver
   always @(posedge clock) begin
      logic offering;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            predict_request(current_request);
            offering = 1'b0;
            gap_left = pick_send_gap();
            sent_count++;
            if (sent_count % 50 == 0) send_gaps_on = ($urandom_range(0, 2) != 0);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_backlog.size() > 0) begin
               current_request = request_backlog.pop_front();
               req_opcode <= current_request.opcode;
               req_led_index <= current_request.led_index;
               req_red_level <= current_request.red;
               req_green_level <= current_request.green;
               req_blue_level <= current_request.blue;
               offering = 1'b1;
            end
         end
         req_valid <= offering;
      end
   end

   // result monitor
   always @(posedge clock) begin
      slot_result_type want;
      logic ready_next;
      int unsigned roll;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_slots.size() == 0) begin
               flag_mismatch("unexpected slot result, duty", 0, 32'(rsp_slot_duty));
            end else begin
               want = expected_slots.pop_front();
               if (rsp_slot_duty !== want.duty)
                  flag_mismatch("slot_duty", 32'(want.duty), 32'(rsp_slot_duty));
               if (rsp_frame_end !== want.frame_end)
                  flag_mismatch("frame_end", 32'(want.frame_end), 32'(rsp_frame_end));
            end
            if (results_seen % 50 == 0) recv_stalls_on = ($urandom_range(0, 2) != 0);
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!recv_stalls_on) begin
            ready_next = 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) hold_left = $urandom_range(10, 60);
            else if (roll < 22) hold_left = $urandom_range(1, 4);
            ready_next = (hold_left == 0);
         end
         rsp_ready <= ready_next;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_op(logic [2:0] op, logic [15:0] idx,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      led_request_type r;
      r.opcode = op;
      r.led_index = idx;
      r.red = red;
      r.green = green;
      r.blue = blue;
      request_backlog.push_back(r);
      if (op != OP_UNUSED) random_items++;
   endtask

   task automatic queue_colored(logic [2:0] op, int unsigned idx);
      queue_op(op, 16'(idx), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
   endtask

   function automatic int unsigned near_led_index();
      return $urandom_range(0, 5) + LED_COUNT * $urandom_range(0, 255);
   endfunction

   function automatic logic [2:0] pick_bulk_op();
      case ($urandom_range(0, 3))
         0: return OP_SET_ALL;
         1: return OP_FILL_BLACK;
         2: return OP_FILL_WHITE;
         default: return OP_CLEAR;
      endcase
   endfunction

   // disturb a running frame without restarting it
   task automatic queue_noise();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) queue_colored(OP_SET_LED, near_led_index());
      else if (roll < 85) queue_colored(pick_bulk_op(), $urandom_range(0, 65535));
      else queue_colored(OP_UNUSED, $urandom_range(0, 65535));
   endtask

   task automatic add_random_chunk(int unsigned target);
      int unsigned goal, roll, ticks;
      goal = random_items + target;
      while (random_items < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            repeat ($urandom_range(0, 3)) queue_colored(OP_SET_LED, near_led_index());
            queue_colored(OP_START, $urandom_range(0, 65535));
            ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(50, 170);
            repeat (ticks) begin
               if ($urandom_range(0, 24) == 0) queue_noise();
               queue_colored(OP_TICK, $urandom_range(0, 65535));
            end
         end else if (roll < 80) begin
            queue_colored(OP_SET_LED, $urandom_range(0, 65535));
         end else if (roll < 84) begin
            queue_colored(pick_bulk_op(), $urandom_range(0, 65535));
         end else if (roll < 92) begin
            queue_colored(OP_TICK, $urandom_range(0, 65535));
         end else if (roll < 96) begin
            queue_colored(OP_UNUSED, $urandom_range(0, 65535));
         end else begin
            queue_colored(3'($urandom_range(0, 7)), $urandom_range(0, 65535));
         end
      end
   endtask

   // hold the sender until every request is in and every result is back
   task automatic wait_quiet();
      @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_slots.size() != 0)
         @(negedge clock);
      repeat (SWEEP_CYCLES) @(posedge clock);
   endtask

   task automatic write_duty_codes(logic [DUTY_W-1:0] zero_code, logic [DUTY_W-1:0] one_code);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= CSR_ZERO_DUTY;
      csr_wdata <= zero_code;
      @(posedge clock);
      csr_index <= CSR_ONE_DUTY;
      csr_wdata <= one_code;
      @(posedge clock);
      csr_wen <= 1'b0;
      zero_duty = zero_code;
      one_duty = one_code;
   endtask

   initial begin
      paint_store('0);
      end_blank = 1'b0;
      frame_running = 1'b0;
      frame_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_op(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_op(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_op(OP_FILL_WHITE, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_CLEAR, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_SET_ALL, 16'h1234, 8'h5A, 8'hC3, 8'h81);
      queue_op(OP_FILL_BLACK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_SET_LED, 16'hFFFF, 8'h00, 8'hFF, 8'h80);
      queue_op(OP_SET_LED, 16'h0000, 8'hA5, 8'h80, 8'h01);
      queue_op(OP_SET_LED, 16'h0101, 8'hFF, 8'hFF, 8'hFF);
      queue_op(OP_SET_LED, 16'h0100, 8'h3C, 8'h7E, 8'h00);
      queue_op(OP_START, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_op(OP_START, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_CLEAR, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_FILL_WHITE, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_op(OP_TICK, 16'h0000, 8'h00, 8'h00, 8'h00);
      wait_quiet();

      write_duty_codes(8'h00, 8'hFF);
      add_random_chunk(CHUNK_ITEMS);
      wait_quiet();

      write_duty_codes(8'hFF, 8'h00);
      add_random_chunk(CHUNK_ITEMS);
      wait_quiet();

      write_duty_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      hold_requests++;
      add_random_chunk(CHUNK_ITEMS);
      wait_quiet();

      write_duty_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      add_random_chunk(CHUNK_ITEMS);
      wait_quiet();

      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
